// ===== rtl/pfwe_pkg.sv =====
// Package: shared types, constants and helpers of the packed field width expander.
`timescale 1ns / 1ps
`default_nettype none

package pfwe_pkg;

  localparam int WORD_W     = 64;
  localparam int FPV_W      = 9;
  localparam int CNT_W      = 4;
  localparam int MAX_FIELDS = 256;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] CFG_SRC_SEL = 2'd0;
  localparam logic [1:0] CFG_TGT_SEL = 2'd1;
  localparam logic [1:0] CFG_FPV     = 2'd2;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } width_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  n;
    logic              vend;
    width_e            src;
    width_e            dst;
  } entry_t;

  function automatic logic [FPV_W-1:0] vector_fields(input logic [FPV_W-1:0] fpv);
    logic [FPV_W-1:0] r;
    r = fpv;
    if (fpv == '0) begin
      r = FPV_W'(1);
    end else if (fpv > FPV_W'(MAX_FIELDS)) begin
      r = FPV_W'(MAX_FIELDS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfwe_front.sv =====
// Front end: configuration registers, field counting and word classification.
`timescale 1ns / 1ps
`default_nettype none

module pfwe_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  input  wire  [pfwe_pkg::WORD_W-1:0] packed_word_i,
  input  wire                         cfg_we_i,
  input  wire  [1:0]                  cfg_index_i,
  input  wire  [pfwe_pkg::FPV_W-1:0]  cfg_data_i,
  input  wire                         fifo_full_i,
  output logic                        fifo_push_o,
  output pfwe_pkg::entry_t            entry_o
);

  logic [1:0]                 src_q, src_d;
  logic [1:0]                 tgt_q, tgt_d;
  logic [pfwe_pkg::FPV_W-1:0] fpv_q, fpv_d;
  logic [pfwe_pkg::FPV_W-1:0] left_q, left_d;

  pfwe_pkg::width_e           s_eff;
  pfwe_pkg::width_e           t_eff;
  logic [pfwe_pkg::CNT_W-1:0] per_in;
  logic [pfwe_pkg::FPV_W-1:0] left_cur;
  logic [pfwe_pkg::FPV_W-1:0] n_full;
  logic [pfwe_pkg::FPV_W-1:0] left_rem;
  logic                       vend;
  logic                       accept;

  always_comb begin
    s_eff  = (src_q == pfwe_pkg::W64) ? pfwe_pkg::W32 : pfwe_pkg::width_e'(src_q);
    t_eff  = (tgt_q < s_eff) ? s_eff : pfwe_pkg::width_e'(tgt_q);
    per_in = pfwe_pkg::CNT_W'(8) >> s_eff;
    if (left_q == '0 || left_q > pfwe_pkg::FPV_W'(pfwe_pkg::MAX_FIELDS)) begin
      left_cur = pfwe_pkg::vector_fields(fpv_q);
    end else begin
      left_cur = left_q;
    end
    n_full   = (left_cur < pfwe_pkg::FPV_W'(per_in)) ? left_cur : pfwe_pkg::FPV_W'(per_in);
    left_rem = left_cur - n_full;
    vend     = (left_rem == '0);
  end

  assign accept      = push_i && !fifo_full_i;
  assign fifo_push_o = accept;

  always_comb begin
    entry_o.word = packed_word_i;
    entry_o.n    = n_full[pfwe_pkg::CNT_W-1:0];
    entry_o.vend = vend;
    entry_o.src  = s_eff;
    entry_o.dst  = t_eff;
  end

  always_comb begin
    src_d  = src_q;
    tgt_d  = tgt_q;
    fpv_d  = fpv_q;
    left_d = left_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        pfwe_pkg::CFG_SRC_SEL: begin
          src_d  = cfg_data_i[1:0];
          left_d = pfwe_pkg::vector_fields(fpv_q);
        end
        pfwe_pkg::CFG_TGT_SEL: begin
          tgt_d  = cfg_data_i[1:0];
          left_d = pfwe_pkg::vector_fields(fpv_q);
        end
        pfwe_pkg::CFG_FPV: begin
          fpv_d  = cfg_data_i;
          left_d = pfwe_pkg::vector_fields(cfg_data_i);
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      left_d = vend ? pfwe_pkg::vector_fields(fpv_q) : left_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= pfwe_pkg::W8;
      tgt_q  <= pfwe_pkg::W64;
      fpv_q  <= pfwe_pkg::FPV_W'(1);
      left_q <= pfwe_pkg::FPV_W'(1);
    end else begin
      src_q  <= src_d;
      tgt_q  <= tgt_d;
      fpv_q  <= fpv_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfwe_fifo.sv =====
// Short queue of classified words between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module pfwe_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  pfwe_pkg::entry_t   entry_i,
  input  wire                pop_i,
  output logic               full_o,
  output logic               empty_o,
  output pfwe_pkg::entry_t   entry_o
);

  pfwe_pkg::entry_t                   mem_q [pfwe_pkg::FIFO_DEPTH];
  logic [pfwe_pkg::FIFO_PTR_W-1:0]    wr_q, wr_d;
  logic [pfwe_pkg::FIFO_PTR_W-1:0]    rd_q, rd_d;
  logic [pfwe_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic                               do_push;
  logic                               do_pop;

  assign full_o  = (cnt_q == pfwe_pkg::FIFO_CNT_W'(pfwe_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == pfwe_pkg::FIFO_PTR_W'(pfwe_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == pfwe_pkg::FIFO_PTR_W'(pfwe_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfwe_back.sv =====
// Back end: emits the widened output words of each queued word, one per cycle unless a held pop stalls it.
`timescale 1ns / 1ps
`default_nettype none

module pfwe_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         fifo_empty_i,
  input  pfwe_pkg::entry_t            entry_i,
  output logic                        fifo_pop_o,
  input  wire                         pop_i,
  output logic                        empty_o,
  output logic [pfwe_pkg::WORD_W-1:0] wide_word_o,
  output logic                        vector_end_o,
  output logic                        run_end_o
);

  logic                        active_q, active_d;
  logic [pfwe_pkg::WORD_W-1:0] sh_q, sh_d;
  logic [pfwe_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic                        vend_q, vend_d;
  pfwe_pkg::width_e            src_q, src_d;
  pfwe_pkg::width_e            dst_q, dst_d;

  logic                        ov_q, ov_d;
  logic [pfwe_pkg::WORD_W-1:0] ow_q, ow_d;
  logic                        ove_q, ove_d;
  logic                        ore_q, ore_d;

  logic                        pass;
  logic [pfwe_pkg::CNT_W-1:0]  per_out;
  logic [6:0]                  shamt;
  logic                        last;
  logic                        emit;
  logic                        fetch;
  logic [31:0]                 fld [4];
  logic [pfwe_pkg::WORD_W-1:0] built;

  assign pass    = (src_q == dst_q);
  assign per_out = pfwe_pkg::CNT_W'(8) >> dst_q;
  assign shamt   = 7'd64 >> (dst_q - src_q);
  assign last    = pass || (rem_q <= per_out);
  assign emit    = active_q && (!ov_q || pop_i);
  assign fetch   = (!active_q || (emit && last)) && !fifo_empty_i;
  assign fifo_pop_o = fetch;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fld[i] = '0;
    end
    case (src_q)
      pfwe_pkg::W8: begin
        for (int i = 0; i < 4; i++) begin
          fld[i] = {24'd0, sh_q[63-8*i -: 8]};
        end
      end
      pfwe_pkg::W16: begin
        for (int i = 0; i < 4; i++) begin
          fld[i] = {16'd0, sh_q[63-16*i -: 16]};
        end
      end
      default: begin
        fld[0] = sh_q[63:32];
        fld[1] = sh_q[31:0];
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      if (pfwe_pkg::CNT_W'(i) >= rem_q) begin
        fld[i] = '0;
      end
    end
    built = '0;
    case (dst_q)
      pfwe_pkg::W16: begin
        for (int i = 0; i < 4; i++) begin
          built[63-16*i -: 16] = fld[i][15:0];
        end
      end
      pfwe_pkg::W32: begin
        built = {fld[0], fld[1]};
      end
      default: begin
        built = {32'd0, fld[0]};
      end
    endcase
    if (pass) begin
      built = sh_q;
    end
  end

  always_comb begin
    active_d = active_q;
    sh_d     = sh_q;
    rem_d    = rem_q;
    vend_d   = vend_q;
    src_d    = src_q;
    dst_d    = dst_q;
    ov_d     = ov_q;
    ow_d     = ow_q;
    ove_d    = ove_q;
    ore_d    = ore_q;
    if (emit) begin
      ov_d  = 1'b1;
      ow_d  = built;
      ove_d = vend_q && last;
      ore_d = last;
      sh_d  = sh_q << shamt;
      rem_d = rem_q - per_out;
      if (last) begin
        active_d = 1'b0;
      end
    end else if (pop_i && ov_q) begin
      ov_d = 1'b0;
    end
    if (fetch) begin
      active_d = 1'b1;
      sh_d     = entry_i.word;
      rem_d    = entry_i.n;
      vend_d   = entry_i.vend;
      src_d    = entry_i.src;
      dst_d    = entry_i.dst;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    vend_q <= vend_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    ow_q   <= ow_d;
    ove_q  <= ove_d;
    ore_q  <= ore_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      ov_q     <= ov_d;
    end
  end

  assign empty_o      = !ov_q;
  assign wide_word_o  = ow_q;
  assign vector_end_o = ove_q;
  assign run_end_o    = ore_q;

endmodule

`default_nettype wire

// ===== rtl/packed_field_width_expander_unit.sv =====
// Top level of the packed field width expander: front end, queue and back end.
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------
//  input    | push / full       | packed_word_i[63:0]
//  result   | empty / pop       | wide_word_o[63:0], vector_end_o, run_end_o
//  config   | cfg_we_i          | cfg_index_i[1:0], cfg_data_i[8:0]
//
// The front end takes one word per cycle, while the queue is not full, into a two-entry queue.
// The back end sends one output word per cycle, unless pop stalls it, from its output register,
// ceil(fields / fields-per-output-word) output words per input word, 1 to 8;
// the next queued word loads in the cycle of the previous word's last output.
// Reset clears the queue and the output register's valid flag and loads the default widths.
// Pop held low with a word waiting stalls the back end; full rises once the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module packed_field_width_expander_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push,
  output logic                        full,
  input  wire  [pfwe_pkg::WORD_W-1:0] packed_word_i,
  output logic                        empty,
  input  wire                         pop,
  output logic [pfwe_pkg::WORD_W-1:0] wide_word_o,
  output logic                        vector_end_o,
  output logic                        run_end_o,
  input  wire                         cfg_we_i,
  input  wire  [1:0]                  cfg_index_i,
  input  wire  [pfwe_pkg::FPV_W-1:0]  cfg_data_i
);

  pfwe_pkg::entry_t front_entry;
  pfwe_pkg::entry_t queue_entry;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  assign full = q_full;

  pfwe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .packed_word_i (packed_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fifo_full_i   (q_full),
    .fifo_push_o   (q_push),
    .entry_o       (front_entry)
  );

  pfwe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .entry_o (queue_entry)
  );

  pfwe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (q_empty),
    .entry_i      (queue_entry),
    .fifo_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .wide_word_o  (wide_word_o),
    .vector_end_o (vector_end_o),
    .run_end_o    (run_end_o)
  );

endmodule

`default_nettype wire
